### rtl/lsae_pkg.sv
package lsae_pkg;

	typedef struct packed {
		logic [7:0] g;
		logic [7:0] r;
		logic [7:0] b;
	} color_t;

	localparam logic [1:0] FUNC_TICK = 2'd0;
	localparam logic [1:0] FUNC_MODE = 2'd1;
	localparam logic [1:0] FUNC_LOAD = 2'd2;
	localparam logic [1:0] FUNC_RSSI = 2'd3;

	localparam logic [2:0] MODE_STATIC  = 3'd0;
	localparam logic [2:0] MODE_FLASH   = 3'd1;
	localparam logic [2:0] MODE_ROTATE  = 3'd2;
	localparam logic [2:0] MODE_THROB   = 3'd3;
	localparam logic [2:0] MODE_RANDOM  = 3'd4;
	localparam logic [2:0] MODE_YELLOW  = 3'd5;
	localparam logic [2:0] MODE_RSSI    = 3'd6;
	localparam logic [2:0] MODE_ONESHOT = 3'd7;

	localparam logic [2:0] OP_SHOW  = 3'd0;
	localparam logic [2:0] OP_FILL  = 3'd1;
	localparam logic [2:0] OP_COPY  = 3'd2;
	localparam logic [2:0] OP_ROT   = 3'd3;
	localparam logic [2:0] OP_THROB = 3'd4;

	localparam logic [7:0]  YELLOW_G       = 8'd170;
	localparam logic [7:0]  YELLOW_R       = 8'd175;
	localparam logic [7:0]  RSSI_OFFSET    = 8'd90;
	localparam logic [7:0]  RSSI_SCALE     = 8'd9;
	localparam logic [7:0]  THROB_STEP_RST = 8'd4;
	localparam logic [15:0] RAND_THR_RST   = 16'd512;

	typedef struct packed {
		logic [2:0] op;
		logic       fading;
		logic [7:0] step;
		color_t     fill;
	} pix_ctl_t;

endpackage

### rtl/lsae_ram.sv
module lsae_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/lsae_pixel_alu.sv
module lsae_pixel_alu (
	input  lsae_pkg::pix_ctl_t ctl,
	input  lsae_pkg::color_t   cur,
	input  lsae_pkg::color_t   pat,
	output lsae_pkg::color_t   nxt,
	output logic               changed
);

	logic [2:0][7:0] cur_v;
	logic [2:0][7:0] pat_v;
	logic [2:0][7:0] thr_v;
	logic [2:0]      chg_v;
	logic [8:0]      diff;

	assign cur_v = cur;
	assign pat_v = pat;

	always_comb begin
		thr_v = '0;
		chg_v = '0;
		diff  = '0;
		for (int c = 0; c < 3; c++) begin
			diff = {1'b0, pat_v[c]} - {1'b0, cur_v[c]};
			if (ctl.fading) begin
				if (cur_v[c] >= ctl.step) begin
					thr_v[c] = cur_v[c] - ctl.step;
					chg_v[c] = 1'b1;
				end else begin
					thr_v[c] = '0;
				end
			end else begin
				if (!diff[8] && (diff[7:0] > ctl.step)) begin
					thr_v[c] = cur_v[c] + ctl.step;
					chg_v[c] = 1'b1;
				end else begin
					thr_v[c] = pat_v[c];
				end
			end
		end
	end

	always_comb begin
		nxt     = cur;
		changed = 1'b0;
		case (ctl.op)
			lsae_pkg::OP_FILL:  nxt = ctl.fill;
			lsae_pkg::OP_COPY:  nxt = pat;
			lsae_pkg::OP_THROB: begin
				nxt     = thr_v;
				changed = |chg_v;
			end
			default:            nxt = cur;
		endcase
	end

endmodule

### rtl/led_string_animation_engine.sv
// a frame's words go out through the registered frame/pattern reads and the output word register,
// one LED per cycle while out_stall does not hold the output, through the shared pixel unit;
// rotate keeps LED 0's colour and sends it last; in_stall holds new items until the last word is emitted,
// while commands, loads without a frame and ticks that emit nothing do not raise in_stall
// reset: arst_n resets the busy, mode and animation control state and clears the per-LED valid bits at once
// (op, fill and the output word are not reset), so frame and pattern read as dark right after reset
module led_string_animation_engine #(
	parameter int LED_COUNT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [2:0]  anim_mode,
	input  logic [15:0] mode_param,
	input  logic [5:0]  led_index,
	input  logic [7:0]  green_level,
	input  logic [7:0]  red_level,
	input  logic [7:0]  blue_level,
	input  logic        last_entry,
	input  logic [14:0] random_value,
	input  logic [7:0]  signal_dbm,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  out_index,
	output logic [7:0]  out_green,
	output logic [7:0]  out_red,
	output logic [7:0]  out_blue,
	output logic        frame_end
);

	localparam int IDX_W = $clog2(LED_COUNT);
	localparam int CNT_W = $clog2(LED_COUNT + 1);
	localparam logic [IDX_W-1:0] LAST = IDX_W'(LED_COUNT - 1);
	localparam logic [CNT_W-1:0] CNT_END = CNT_W'(LED_COUNT);

	logic                  busy_q;
	logic [2:0]            op_q;
	lsae_pkg::color_t      fill_q;
	logic [CNT_W-1:0]      rd_cnt_q;
	logic                  vld_s1;
	logic [IDX_W-1:0]      k_s1;
	logic                  fv_s1;
	logic                  pv_s1;
	lsae_pkg::color_t      saved_q;
	logic                  tail_q;
	logic                  changed_q;
	logic [LED_COUNT-1:0]  fval_q;
	logic [LED_COUNT-1:0]  pval_q;
	logic [2:0]            mode_q;
	logic                  phase_q;
	logic                  fading_q;
	logic [7:0]            step_q;
	logic [15:0]           thr_q;
	logic                  pend_q;
	logic [7:0]            avg_q;
	logic                  oval_q;
	logic [5:0]            oidx_q;
	lsae_pkg::color_t      ocol_q;
	logic                  oend_q;

	logic                  in_acc;
	logic                  adv;
	logic                  issue;
	logic [IDX_W-1:0]      raddr;
	lsae_pkg::color_t      f_rdata;
	lsae_pkg::color_t      p_rdata;
	lsae_pkg::color_t      cur;
	lsae_pkg::color_t      pat;
	lsae_pkg::color_t      nxt;
	logic                  chg;
	lsae_pkg::pix_ctl_t    ctl;
	logic                  is_rot;
	logic                  proc;
	logic                  tail_go;
	logic                  last_proc;
	logic                  done;
	logic                  emit;
	logic [IDX_W-1:0]      eidx;
	lsae_pkg::color_t      ecol;
	logic                  save_first;
	logic                  load_ok;
	logic                  fw_en;
	logic [IDX_W-1:0]      fw_addr;
	lsae_pkg::color_t      fw_data;
	logic                  pw_en;
	lsae_pkg::color_t      ld_col;
	logic                  start;
	logic [2:0]            start_op;
	lsae_pkg::color_t      start_fill;
	logic [7:0]            rssi_x;
	logic [7:0]            rssi_latest;

	assign in_stall = busy_q;
	assign in_acc   = in_valid && !busy_q;
	assign adv      = !oval_q || !out_stall;
	assign issue    = busy_q && adv && (rd_cnt_q != CNT_END);
	assign raddr    = rd_cnt_q[IDX_W-1:0];

	assign ld_col   = '{g: green_level, r: red_level, b: blue_level};
	assign load_ok  = (7'(led_index) < 7'(LED_COUNT));

	assign cur = fv_s1 ? f_rdata : '0;
	assign pat = pv_s1 ? p_rdata : '0;

	assign ctl = '{op: op_q, fading: fading_q, step: step_q, fill: fill_q};

	lsae_pixel_alu u_alu (
		.ctl     (ctl),
		.cur     (cur),
		.pat     (pat),
		.nxt     (nxt),
		.changed (chg)
	);

	assign is_rot    = (op_q == lsae_pkg::OP_ROT);
	assign proc      = adv && vld_s1;
	assign tail_go   = adv && tail_q;
	assign last_proc = proc && (k_s1 == LAST);
	assign done      = tail_go || (last_proc && !is_rot);

	always_comb begin
		emit       = 1'b0;
		eidx       = k_s1;
		ecol       = nxt;
		save_first = 1'b0;
		if (tail_go) begin
			emit = 1'b1;
			eidx = LAST;
			ecol = saved_q;
		end else if (proc) begin
			if (is_rot) begin
				if (k_s1 == '0) begin
					save_first = 1'b1;
				end else begin
					emit = 1'b1;
					eidx = k_s1 - 1'b1;
					ecol = cur;
				end
			end else begin
				emit = 1'b1;
			end
		end
	end

	always_comb begin
		if (busy_q) begin
			fw_en   = emit;
			fw_addr = eidx;
			fw_data = ecol;
		end else begin
			fw_en   = in_acc && (func == lsae_pkg::FUNC_LOAD) && load_ok;
			fw_addr = led_index[IDX_W-1:0];
			fw_data = ld_col;
		end
	end
	assign pw_en = !busy_q && fw_en;

	lsae_ram #(.WIDTH($bits(lsae_pkg::color_t)), .DEPTH(LED_COUNT)) u_frame (
		.clk   (clk),
		.we    (fw_en),
		.waddr (fw_addr),
		.wdata (fw_data),
		.re    (issue),
		.raddr (raddr),
		.rdata (f_rdata)
	);

	lsae_ram #(.WIDTH($bits(lsae_pkg::color_t)), .DEPTH(LED_COUNT)) u_pattern (
		.clk   (clk),
		.we    (pw_en),
		.waddr (fw_addr),
		.wdata (fw_data),
		.re    (issue),
		.raddr (raddr),
		.rdata (p_rdata)
	);

	// decide what a tick or a final load does to the frame
	always_comb begin
		start      = 1'b0;
		start_op   = lsae_pkg::OP_SHOW;
		start_fill = '0;
		if (func == lsae_pkg::FUNC_TICK) begin
			case (mode_q)
				lsae_pkg::MODE_FLASH: begin
					start    = 1'b1;
					start_op = phase_q ? lsae_pkg::OP_COPY : lsae_pkg::OP_FILL;
				end
				lsae_pkg::MODE_ROTATE: begin
					start    = 1'b1;
					start_op = lsae_pkg::OP_ROT;
				end
				lsae_pkg::MODE_THROB: begin
					start    = 1'b1;
					start_op = lsae_pkg::OP_THROB;
				end
				lsae_pkg::MODE_RANDOM: begin
					start    = 1'b1;
					start_op = ({1'b0, random_value} <= thr_q) ?
						lsae_pkg::OP_COPY : lsae_pkg::OP_FILL;
				end
				lsae_pkg::MODE_YELLOW: begin
					start      = 1'b1;
					start_op   = lsae_pkg::OP_FILL;
					start_fill = '{g: lsae_pkg::YELLOW_G, r: lsae_pkg::YELLOW_R, b: 8'd0};
				end
				lsae_pkg::MODE_RSSI: begin
					start      = 1'b1;
					start_op   = lsae_pkg::OP_FILL;
					start_fill = '{g: 8'd0, r: avg_q, b: ~avg_q};
				end
				lsae_pkg::MODE_ONESHOT: begin
					start    = pend_q;
					start_op = lsae_pkg::OP_FILL;
				end
				default: start = 1'b0;
			endcase
		end else if (func == lsae_pkg::FUNC_LOAD) begin
			start    = last_entry;
			start_op = lsae_pkg::OP_SHOW;
		end
	end

	assign rssi_x      = signal_dbm + lsae_pkg::RSSI_OFFSET;
	assign rssi_latest = 8'(rssi_x * lsae_pkg::RSSI_SCALE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			rd_cnt_q  <= '0;
			vld_s1    <= 1'b0;
			tail_q    <= 1'b0;
			changed_q <= 1'b0;
			fval_q    <= '0;
			pval_q    <= '0;
			mode_q    <= lsae_pkg::MODE_STATIC;
			phase_q   <= 1'b0;
			fading_q  <= 1'b0;
			step_q    <= lsae_pkg::THROB_STEP_RST;
			thr_q     <= lsae_pkg::RAND_THR_RST;
			pend_q    <= 1'b0;
			avg_q     <= '0;
			oval_q    <= 1'b0;
		end else begin
			if (fw_en) begin
				fval_q[fw_addr] <= 1'b1;
			end
			if (pw_en) begin
				pval_q[fw_addr] <= 1'b1;
			end

			if (in_acc) begin
				case (func)
					lsae_pkg::FUNC_MODE: begin
						mode_q <= anim_mode;
						case (anim_mode)
							lsae_pkg::MODE_FLASH:   phase_q <= 1'b0;
							lsae_pkg::MODE_RANDOM:  thr_q <= mode_param;
							lsae_pkg::MODE_THROB: begin
								step_q   <= mode_param[7:0];
								fading_q <= 1'b1;
							end
							lsae_pkg::MODE_ONESHOT: pend_q <= 1'b1;
							default:                pend_q <= pend_q;
						endcase
					end
					lsae_pkg::FUNC_RSSI: begin
						avg_q <= 8'({2'b00, avg_q[7:2]} * 8'd3) + rssi_latest;
					end
					lsae_pkg::FUNC_TICK: begin
						if (mode_q == lsae_pkg::MODE_FLASH) begin
							phase_q <= !phase_q;
						end
						if (mode_q == lsae_pkg::MODE_ONESHOT) begin
							pend_q <= 1'b0;
						end
					end
					default: pend_q <= pend_q;
				endcase
				if (start) begin
					busy_q    <= 1'b1;
					rd_cnt_q  <= '0;
					tail_q    <= 1'b0;
					changed_q <= 1'b0;
				end
			end

			if (adv) begin
				vld_s1 <= issue;
			end
			if (issue) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
			if (proc && (op_q == lsae_pkg::OP_THROB)) begin
				changed_q <= changed_q | chg;
			end
			if (last_proc && is_rot) begin
				tail_q <= 1'b1;
			end
			if (tail_go) begin
				tail_q <= 1'b0;
			end
			if (done) begin
				busy_q <= 1'b0;
				if ((op_q == lsae_pkg::OP_THROB) && !(changed_q || chg)) begin
					fading_q <= !fading_q;
				end
			end

			if (emit) begin
				oval_q <= 1'b1;
			end else if (adv) begin
				oval_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && start) begin
			op_q   <= start_op;
			fill_q <= start_fill;
		end
		if (issue) begin
			k_s1  <= raddr;
			fv_s1 <= fval_q[raddr];
			pv_s1 <= pval_q[raddr];
		end
		if (save_first) begin
			saved_q <= cur;
		end
		if (emit) begin
			oidx_q <= 6'(eidx);
			ocol_q <= ecol;
			oend_q <= (eidx == LAST);
		end
	end

	assign out_valid = oval_q;
	assign out_index = oidx_q;
	assign out_green = ocol_q.g;
	assign out_red   = ocol_q.r;
	assign out_blue  = ocol_q.b;
	assign frame_end = oend_q;

endmodule

### rtl/lsae_checker.sv
module lsae_checker #(
	parameter int LED_COUNT = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  func,
	input logic [2:0]  anim_mode,
	input logic [15:0] mode_param,
	input logic [5:0]  led_index,
	input logic [7:0]  green_level,
	input logic [7:0]  red_level,
	input logic [7:0]  blue_level,
	input logic        last_entry,
	input logic [14:0] random_value,
	input logic [7:0]  signal_dbm,
	input logic        out_valid,
	input logic        out_stall,
	input logic [5:0]  out_index,
	input logic [7:0]  out_green,
	input logic [7:0]  out_red,
	input logic [7:0]  out_blue,
	input logic        frame_end
);

	// stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_index) && $stable(out_green)
			&& $stable(out_red) && $stable(out_blue) && $stable(frame_end))
		else $error("stalled output word changed");

	// frame end only on the last led
	a_end_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> out_index == 6'(LED_COUNT - 1))
		else $error("frame end on wrong led");

	// no new item while a frame is still going out
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_end |-> in_stall)
		else $error("input taken mid frame");

	// a taken last word is not followed at once by another word
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && frame_end |=> !out_valid)
		else $error("word right after frame end");

endmodule

bind led_string_animation_engine lsae_checker #(.LED_COUNT(LED_COUNT)) u_lsae_checker (.*);
